// File: rtl/bcpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_pkg
// Shared types, codes and the GF(2^n) multiply for the binary curve point adder.
// ----------------------------------------------------------------------------
package bcpa_pkg;

    localparam int MAX_DEGREE = 16;
    localparam int W          = 16;
    localparam int INV_CELLS  = MAX_DEGREE - 1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CURVE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        K_Q   = 3'd0,
        K_P   = 3'd1,
        K_INF = 3'd2,
        K_DBL = 3'd3,
        K_ADD = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CFG_DEGREE = 3'd0,
        CFG_POLY   = 3'd1,
        CFG_A      = 3'd2,
        CFG_B      = 3'd3,
        CFG_QX     = 3'd4,
        CFG_QY     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0]   deg;
        logic [W-1:0] mask;
        logic [W:0]   red;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] qx;
        logic [W-1:0] qy;
    } t_fld;

    typedef struct packed {
        logic [W-1:0] px;
        logic [W-1:0] py;
        logic [W-1:0] sqx;
        logic [W-1:0] chk;
        logic [W-1:0] num;
        logic [W-1:0] r;
        logic [W-1:0] base;
        logic [4:0]   step;
        t_kind        kind;
        t_status      st;
    } t_ctx;

    typedef struct packed {
        logic [W-1:0] x;
        logic [W-1:0] y;
        t_status      st;
    } t_res;

    function automatic logic [W-1:0] gf_mul(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input t_fld f);
        logic [W:0]   xs;
        logic [W:0]   top;
        logic [W-1:0] acc;
        top = (W+1)'(1) << f.deg;
        xs  = {1'b0, x};
        acc = '0;
        for (int i = 0; i < W; i++) begin
            if (5'(i) < f.deg) begin
                if (y[i]) acc = acc ^ xs[W-1:0];
                xs = xs << 1;
                if ((xs & top) != '0) xs = xs ^ f.red;
            end
        end
        return acc;
    endfunction

endpackage

// File: rtl/bcpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_front
// Two stages: range check, case decode and squares, then the curve check.
// ----------------------------------------------------------------------------
module bcpa_front import bcpa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  t_fld         i_fld,
    input  logic         i_vld,
    input  logic [W-1:0] i_px,
    input  logic [W-1:0] i_py,
    output logic         o_vld,
    output t_ctx         o_ctx
);

    logic r_vld_a, r_vld_b;
    t_ctx r_ctx_a, r_ctx_b;
    t_ctx n_ctx_a, n_ctx_b;

    always_comb begin
        logic [W-1:0] d;
        n_ctx_a      = '0;
        n_ctx_a.px   = i_px;
        n_ctx_a.py   = i_py;
        n_ctx_a.sqx  = gf_mul(i_px, i_px, i_fld);
        n_ctx_a.chk  = gf_mul(i_py, i_py, i_fld) ^ gf_mul(i_px, i_py, i_fld);
        n_ctx_a.r    = W'(1);
        n_ctx_a.step = 5'd1;
        n_ctx_a.st   = ((i_px & ~i_fld.mask) != '0 || (i_py & ~i_fld.mask) != '0)
                       ? ST_RANGE : ST_OK;
        if (i_px == '0 && i_py == '0) begin
            n_ctx_a.kind = K_Q;
        end else if (i_fld.qx == '0 && i_fld.qy == '0) begin
            n_ctx_a.kind = K_P;
        end else if (i_px == i_fld.qx) begin
            n_ctx_a.kind = (i_py == i_fld.qy && i_px != '0) ? K_DBL : K_INF;
        end else begin
            n_ctx_a.kind = K_ADD;
        end
        // doubling inverts x, addition inverts the x difference
        d           = (n_ctx_a.kind == K_DBL) ? i_px : (i_px ^ i_fld.qx);
        n_ctx_a.num = (n_ctx_a.kind == K_DBL) ? i_py : (i_py ^ i_fld.qy);
        n_ctx_a.base = gf_mul(d, d, i_fld);
    end

    always_comb begin
        logic [W-1:0] rhs;
        n_ctx_b = r_ctx_a;
        rhs = gf_mul(r_ctx_a.sqx, r_ctx_a.px, i_fld) ^ gf_mul(i_fld.a, r_ctx_a.sqx, i_fld)
              ^ i_fld.b;
        if (r_ctx_a.st == ST_OK && r_ctx_a.kind != K_Q && r_ctx_a.chk != rhs) begin
            n_ctx_b.st = ST_CURVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_adv) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctx_a <= n_ctx_a;
            r_ctx_b <= n_ctx_b;
        end
    end

    assign o_vld = r_vld_b;
    assign o_ctx = r_ctx_b;

endmodule

// File: rtl/bcpa_inv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_inv_cell
// One link of the inversion chain: folds in one power d^(2^k) while k < n.
// ----------------------------------------------------------------------------
module bcpa_inv_cell import bcpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_fld i_fld,
    input  logic i_vld,
    input  t_ctx i_ctx,
    output logic o_vld,
    output t_ctx o_ctx
);

    logic r_vld;
    t_ctx r_ctx;
    t_ctx n_ctx;

    always_comb begin
        n_ctx      = i_ctx;
        n_ctx.base = gf_mul(i_ctx.base, i_ctx.base, i_fld);
        n_ctx.step = i_ctx.step + 5'd1;
        if (i_ctx.step < i_fld.deg) begin
            n_ctx.r = gf_mul(i_ctx.r, i_ctx.base, i_fld);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctx <= n_ctx;
        end
    end

    assign o_vld = r_vld;
    assign o_ctx = r_ctx;

endmodule

// File: rtl/bcpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_back
// Three stages: slope, x of the sum, y of the sum and result selection.
// ----------------------------------------------------------------------------
module bcpa_back import bcpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_fld i_fld,
    input  logic i_vld,
    input  t_ctx i_ctx,
    output logic o_vld,
    output t_res o_res
);

    logic r_vld_l, r_vld_x, r_vld_y;
    t_ctx r_ctx_l, r_ctx_x;
    t_ctx n_ctx_l, n_ctx_x;
    t_res r_res;
    t_res n_res;

    // slope kept in r, x of the sum kept in base
    always_comb begin
        n_ctx_l   = i_ctx;
        n_ctx_l.r = gf_mul(i_ctx.num, i_ctx.r, i_fld) ^ ((i_ctx.kind == K_DBL) ? i_ctx.px : '0);
    end

    always_comb begin
        n_ctx_x      = r_ctx_l;
        n_ctx_x.base = gf_mul(r_ctx_l.r, r_ctx_l.r, i_fld) ^ r_ctx_l.r ^ i_fld.a
                       ^ ((r_ctx_l.kind == K_ADD) ? (r_ctx_l.px ^ i_fld.qx) : '0);
    end

    always_comb begin
        logic [W-1:0] t;
        if (r_ctx_x.kind == K_DBL) begin
            t = gf_mul(r_ctx_x.r ^ W'(1), r_ctx_x.base, i_fld) ^ r_ctx_x.sqx;
        end else begin
            t = gf_mul(r_ctx_x.r, r_ctx_x.px ^ r_ctx_x.base, i_fld) ^ r_ctx_x.base
                ^ r_ctx_x.py;
        end
        n_res.st = r_ctx_x.st;
        n_res.x  = '0;
        n_res.y  = '0;
        if (r_ctx_x.st == ST_OK) begin
            case (r_ctx_x.kind)
                K_Q: begin
                    n_res.x = i_fld.qx;
                    n_res.y = i_fld.qy;
                end
                K_P: begin
                    n_res.x = r_ctx_x.px;
                    n_res.y = r_ctx_x.py;
                end
                K_DBL, K_ADD: begin
                    n_res.x = r_ctx_x.base;
                    n_res.y = t;
                end
                default: begin
                    n_res.x = '0;
                    n_res.y = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_l <= 1'b0;
            r_vld_x <= 1'b0;
            r_vld_y <= 1'b0;
        end else if (i_adv) begin
            r_vld_l <= i_vld;
            r_vld_x <= r_vld_l;
            r_vld_y <= r_vld_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctx_l <= n_ctx_l;
            r_ctx_x <= n_ctx_x;
            r_res   <= n_res;
        end
    end

    assign o_vld = r_vld_y;
    assign o_res = r_res;

endmodule

// File: rtl/binary_curve_point_add_top.sv
`timescale 1ns / 1ps
// the pipeline has 2 check, 15 inversion and 3 output stages from input transfer to result
// throughput: one point per cycle; the pipeline advances as a whole while the result
//   register is empty or being taken
// inversion is a chain of 15 cells, one power of the divisor folded in per cell
// reset (synchronous, active low) clears all stage valid bits and loads the
//   configuration defaults n=4, poly=0x13, a=2, b=6, addend=(0,0)
// ----------------------------------------------------------------------------
// binary_curve_point_add_top
// Adds a configured affine point to each input point on a binary curve.
// ----------------------------------------------------------------------------
module binary_curve_point_add_top import bcpa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [16:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [W-1:0] i_point_x,
    input  logic [W-1:0] i_point_y,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [W-1:0] o_sum_x,
    output logic [W-1:0] o_sum_y,
    output logic [1:0]   o_status
);

    logic [4:0]   r_degree;
    logic [16:0]  r_poly;
    logic [W-1:0] r_a, r_b, r_qx, r_qy;
    t_fld         fld;
    logic         adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 5'd4;
            r_poly   <= 17'h13;
            r_a      <= 16'd2;
            r_b      <= 16'd6;
            r_qx     <= '0;
            r_qy     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEGREE: r_degree <= i_cfg_data[4:0];
                CFG_POLY:   r_poly   <= i_cfg_data;
                CFG_A:      r_a      <= i_cfg_data[W-1:0];
                CFG_B:      r_b      <= i_cfg_data[W-1:0];
                CFG_QX:     r_qx     <= i_cfg_data[W-1:0];
                CFG_QY:     r_qy     <= i_cfg_data[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [4:0] d;
        d = r_degree;
        if (d < 5'd2) d = 5'd2;
        if (d > 5'(MAX_DEGREE)) d = 5'(MAX_DEGREE);
        fld.deg  = d;
        fld.mask = W'(((W+1)'(1) << d) - (W+1)'(1));
        fld.red  = ((W+1)'(1) << d) | (r_poly & {1'b0, fld.mask});
        fld.a    = r_a & fld.mask;
        fld.b    = r_b & fld.mask;
        fld.qx   = r_qx & fld.mask;
        fld.qy   = r_qy & fld.mask;
    end

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    logic vld_c [INV_CELLS+1];
    t_ctx ctx_c [INV_CELLS+1];
    t_res res;

    bcpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_fld   (fld),
        .i_vld   (i_valid),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .o_vld   (vld_c[0]),
        .o_ctx   (ctx_c[0])
    );

    for (genvar k = 0; k < INV_CELLS; k++) begin : g_inv
        bcpa_inv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_fld   (fld),
            .i_vld   (vld_c[k]),
            .i_ctx   (ctx_c[k]),
            .o_vld   (vld_c[k+1]),
            .o_ctx   (ctx_c[k+1])
        );
    end

    bcpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_fld   (fld),
        .i_vld   (vld_c[INV_CELLS]),
        .i_ctx   (ctx_c[INV_CELLS]),
        .o_vld   (o_valid),
        .o_res   (res)
    );

    assign o_sum_x  = res.x;
    assign o_sum_y  = res.y;
    assign o_status = res.st;

    // an error status always carries the point at infinity
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_sum_x == '0 && o_sum_y == '0))
        else $error("error result with nonzero coordinates");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while result register free");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_RANGE || o_status == ST_CURVE))
        else $error("undefined status code");

endmodule
